// ----- rtl/ps2s1_pkg.sv -----
package ps2s1_pkg;

  // Scan byte constants
  localparam logic [7:0] PrefixExt   = 8'hE0;
  localparam logic [7:0] PrtScMake   = 8'h2A;
  localparam logic [7:0] PrtScBreak  = 8'hB7;
  localparam logic [6:0] RomTop      = 7'h39;

  // Assigned virtual key codes
  localparam logic [7:0] KcEsc    = 8'h80;
  localparam logic [7:0] KcLCtrl  = 8'h81;
  localparam logic [7:0] KcLShift = 8'h82;
  localparam logic [7:0] KcRShift = 8'h83;
  localparam logic [7:0] KcLAlt   = 8'h84;
  localparam logic [7:0] KcNone   = 8'h00;

  // Prefix tracking, one-hot
  typedef enum logic [2:0] {
    PS_PLAIN = 3'b001,
    PS_EXT   = 3'b010,
    PS_PRTSC = 3'b100
  } prefix_state_e;

  // One key message
  typedef struct packed {
    logic       key_released;
    logic [7:0] key_code;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
  } key_msg_t;

  // US layout key map for codes 0x00 to 0x39, zero means unmapped
  function automatic logic [7:0] key_lookup(input logic [6:0] idx);
    logic [7:0] kc;
    unique case (idx)
      7'h01: kc = KcEsc;
      7'h02: kc = 8'h31;
      7'h03: kc = 8'h32;
      7'h04: kc = 8'h33;
      7'h05: kc = 8'h34;
      7'h06: kc = 8'h35;
      7'h07: kc = 8'h36;
      7'h08: kc = 8'h37;
      7'h09: kc = 8'h38;
      7'h0A: kc = 8'h39;
      7'h0B: kc = 8'h30;
      7'h0C: kc = 8'h2D;
      7'h0D: kc = 8'h3D;
      7'h0E: kc = 8'h08;
      7'h0F: kc = 8'h09;
      7'h10: kc = 8'h51;
      7'h11: kc = 8'h57;
      7'h12: kc = 8'h45;
      7'h13: kc = 8'h52;
      7'h14: kc = 8'h54;
      7'h15: kc = 8'h59;
      7'h16: kc = 8'h55;
      7'h17: kc = 8'h49;
      7'h18: kc = 8'h4F;
      7'h19: kc = 8'h50;
      7'h1A: kc = 8'h5B;
      7'h1B: kc = 8'h5D;
      7'h1C: kc = 8'h0A;
      7'h1D: kc = KcLCtrl;
      7'h1E: kc = 8'h41;
      7'h1F: kc = 8'h53;
      7'h20: kc = 8'h44;
      7'h21: kc = 8'h46;
      7'h22: kc = 8'h47;
      7'h23: kc = 8'h48;
      7'h24: kc = 8'h4A;
      7'h25: kc = 8'h4B;
      7'h26: kc = 8'h4C;
      7'h27: kc = 8'h3B;
      7'h28: kc = 8'h27;
      7'h29: kc = 8'h60;
      7'h2A: kc = KcLShift;
      7'h2B: kc = 8'h5C;
      7'h2C: kc = 8'h5A;
      7'h2D: kc = 8'h58;
      7'h2E: kc = 8'h43;
      7'h2F: kc = 8'h56;
      7'h30: kc = 8'h42;
      7'h31: kc = 8'h4E;
      7'h32: kc = 8'h4D;
      7'h33: kc = 8'h2C;
      7'h34: kc = 8'h2E;
      7'h35: kc = 8'h2F;
      7'h36: kc = KcRShift;
      7'h37: kc = 8'h2A;
      7'h38: kc = KcLAlt;
      7'h39: kc = 8'h20;
      default: kc = KcNone;
    endcase
    return kc;
  endfunction

endpackage

// ----- rtl/ps2_set1_scan_code_decoder.sv -----
// PS/2 scan code set 1 decoder.
// A key message reaches the output after its byte has passed the input register
// and the message has been loaded into the result register.
// Throughput: one byte per cycle; the only stall is a full result register.
// Reset: asynchronous, active low; clears prefix tracking, modifier flags and valids.
module ps2_set1_scan_code_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       scan_byte_valid_i,
  output logic       scan_byte_ready_o,
  input  logic [7:0] scan_byte_i,
  output logic       key_valid_o,
  input  logic       key_ready_i,
  output logic       key_released_o,
  output logic [7:0] key_code_o,
  output logic       shift_held_o,
  output logic       ctrl_held_o,
  output logic       alt_held_o
);
  import ps2s1_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;
  logic       res_valid;
  logic       out_free;
  key_msg_t   res;
  key_msg_t   msg;

  // Input register
  ps2s1_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (scan_byte_valid_i),
    .ready_o  (scan_byte_ready_o),
    .byte_i   (scan_byte_i),
    .advance_i(advance),
    .valid_o  (byte_valid),
    .byte_o   (byte_q)
  );

  // Lookup and prefix/modifier tracking
  ps2s1_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_valid),
    .byte_i      (byte_q),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  ps2s1_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && res_valid),
    .msg_i  (res),
    .free_o (out_free),
    .valid_o(key_valid_o),
    .ready_i(key_ready_i),
    .msg_o  (msg)
  );

  assign key_released_o = msg.key_released;
  assign key_code_o     = msg.key_code;
  assign shift_held_o   = msg.shift_held;
  assign ctrl_held_o    = msg.ctrl_held;
  assign alt_held_o     = msg.alt_held;

endmodule

// ----- rtl/ps2s1_decode.sv -----
module ps2s1_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  logic                out_free_i,
  output logic                advance_o,
  output logic                res_valid_o,
  output ps2s1_pkg::key_msg_t res_o
);
  import ps2s1_pkg::*;

  prefix_state_e state_q, state_d;
  logic          shift_q, shift_d;
  logic          ctrl_q, ctrl_d;
  logic          alt_q, alt_d;
  logic [7:0]    kc;
  logic          mapped;
  logic          down;

  // Key map lookup
  assign kc     = key_lookup(byte_i[6:0]);
  assign mapped = (byte_i[6:0] <= RomTop) && (kc != KcNone);
  assign down   = ~byte_i[7];

  // Prefix tracking and modifier update
  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    ctrl_d      = ctrl_q;
    alt_d       = alt_q;
    res_valid_o = 1'b0;
    unique case (state_q)
      PS_EXT: begin
        state_d = ((byte_i == PrtScMake) || (byte_i == PrtScBreak)) ? PS_PRTSC : PS_PLAIN;
      end
      PS_PRTSC: begin
        state_d = (byte_i == PrefixExt) ? PS_PRTSC : PS_PLAIN;
      end
      default: begin
        state_d = PS_PLAIN;
        if (byte_i == PrefixExt) begin
          state_d = PS_EXT;
        end else if (mapped) begin
          res_valid_o = 1'b1;
          if ((kc == KcLShift) || (kc == KcRShift)) begin
            shift_d = down;
          end else if (kc == KcLCtrl) begin
            ctrl_d = down;
          end else if (kc == KcLAlt) begin
            alt_d = down;
          end
        end
      end
    endcase
  end

  // A byte without a message never waits on the output side
  assign advance_o = byte_valid_i && (!res_valid_o || out_free_i);

  assign res_o.key_released = byte_i[7];
  assign res_o.key_code     = kc;
  assign res_o.shift_held   = shift_d;
  assign res_o.ctrl_held    = ctrl_d;
  assign res_o.alt_held     = alt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_PLAIN;
      shift_q <= 1'b0;
      ctrl_q  <= 1'b0;
      alt_q   <= 1'b0;
    end else if (advance_o) begin
      state_q <= state_d;
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      alt_q   <= alt_d;
    end
  end

  // A prefix seen in the plain state arms the extended state
  a_prefix_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && (state_q == PS_PLAIN) && (byte_i == PrefixExt) |=> state_q == PS_EXT)
    else $error("prefix byte did not arm extended state");

  // Messages only come from the plain state
  a_msg_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (state_q != PS_EXT) && (state_q != PS_PRTSC))
    else $error("message raised inside a prefix sequence");

  // A message always carries a mapped code
  a_msg_mapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.key_code != KcNone)
    else $error("message with unmapped key code");

  // Modifier flags change only when a byte moves on
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_o |=> $stable({shift_q, ctrl_q, alt_q}) && $stable(state_q))
    else $error("decoder state changed without a transfer");

endmodule

// ----- rtl/ps2s1_out_reg.sv -----
module ps2s1_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ps2s1_pkg::key_msg_t msg_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output ps2s1_pkg::key_msg_t msg_o
);
  import ps2s1_pkg::*;

  logic     valid_q;
  key_msg_t msg_q;

  // Register is free when empty or being drained this cycle
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign msg_o   = msg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      msg_q <= msg_i;
    end
  end

endmodule

// ----- rtl/ps2s1_top_dummy_guard.sv -----
module ps2s1_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  logic       valid_q;
  logic [7:0] byte_q;

  // Take a new byte when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

endmodule
